### rtl/seeded_four_lane_name_hash_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the seeded four-lane name hash
// Concurrent checks on i_clk, disabled while i_rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SEEDED_FOUR_LANE_NAME_HASH_MACROS_SVH
`define SEEDED_FOUR_LANE_NAME_HASH_MACROS_SVH

`ifndef SYNTHESIS
`define SFLNH_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sflnh: same-cycle check failed");
`define SFLNH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sflnh: next-cycle check failed");
`else
`define SFLNH_ASSERT_SAME(label, ante, cons)
`define SFLNH_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/sflnh_pkg.sv
// ----------------------------------------------------------------------------
// sflnh_pkg
// Constants and types shared by the seeded four-lane name hash.
// ----------------------------------------------------------------------------
`default_nettype none

package sflnh_pkg;

    localparam logic [31:0] MUL_A = 32'h5724c9d1;
    localparam logic [31:0] MUL_B = 32'h6a511717;
    localparam logic [31:0] MUL_C = 32'h76459457;
    localparam logic [31:0] MUL_D = 32'h51a97a23;

    localparam int unsigned BUCKET_W = 9;

    localparam logic [2:0] CNT_ONE   = 3'd1;
    localparam logic [2:0] CNT_TWO   = 3'd2;
    localparam logic [2:0] CNT_THREE = 3'd3;
    localparam logic [2:0] CNT_FULL  = 3'd4;

    typedef struct packed {
        logic        run;
        logic [31:0] n;
    } t_fold;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } t_hash;

endpackage

`default_nettype wire

### rtl/sflnh_word_fold.sv
// ----------------------------------------------------------------------------
// sflnh_word_fold
// Turns one data beat into the round word: a full word as is, or a 1 to 3
// byte tail folded with sign-extended bytes and the byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sflnh_word_fold (
    input  logic [31:0]       i_data_word,
    input  logic [2:0]        i_byte_count,
    output sflnh_pkg::t_fold  o_fold
);
    import sflnh_pkg::*;

    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] s2;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] cnt_hi;

    always_comb begin
        s0     = {{24{i_data_word[7]}},  i_data_word[7:0]};
        s1     = {{24{i_data_word[15]}}, i_data_word[15:8]};
        s2     = {{24{i_data_word[23]}}, i_data_word[23:16]};
        // 0xff * s1 and 0xffff * s2, mod 2^32
        t1     = (s1 << 8) - s1;
        t2     = (s2 << 16) - s2;
        cnt_hi = {5'b0, i_byte_count, 24'h0};

        o_fold.run = 1'b0;
        o_fold.n   = i_data_word;
        case (i_byte_count)
            CNT_FULL: begin
                o_fold.run = 1'b1;
            end
            CNT_THREE: begin
                o_fold.run = 1'b1;
                o_fold.n   = cnt_hi + t2 + t1 + s0;
            end
            CNT_TWO: begin
                o_fold.run = 1'b1;
                o_fold.n   = cnt_hi + t1 + s0;
            end
            CNT_ONE: begin
                o_fold.run = 1'b1;
                o_fold.n   = cnt_hi + s0;
            end
            default: begin
                o_fold.run = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/seeded_four_lane_name_hash.sv
// ----------------------------------------------------------------------------
// seeded_four_lane_name_hash
// Seeded 128-bit hash of a streamed name plus bucket index.
//
//   channel   direction  handshake                 payload
//   cfg       in         i_cfg_wr_en               i_cfg_wr_data (global seed)
//   in        in         i_in_valid / o_in_stall   start, last, seed, length, word, count
//   out       out        o_out_valid / i_out_stall hash words 0..3, bucket
//
// One beat per cycle sustained while no output stall backs up to the input; a beat
// updates the lanes as it leaves the input register (one 32x32 multiply per lane).
// A result is offered after its last beat passes through the lane snapshot,
// finalize, reciprocal multiply, quotient multiply and remainder correction stages.
// Synchronous active-low reset clears valids, lanes and the global seed.
// An output stall holds all full stages behind it at once; empty ones keep taking beats.
// ----------------------------------------------------------------------------
`default_nettype none
`include "seeded_four_lane_name_hash_macros.svh"

module seeded_four_lane_name_hash #(
    parameter int unsigned BUCKET_COUNT = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [63:0]                     i_cfg_wr_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_start_req,
    input  logic                            i_last,
    input  logic [63:0]                     i_name_seed,
    input  logic [15:0]                     i_total_length,
    input  logic [31:0]                     i_data_word,
    input  logic [2:0]                      i_byte_count,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [31:0]                     o_hash_word0,
    output logic [31:0]                     o_hash_word1,
    output logic [31:0]                     o_hash_word2,
    output logic [31:0]                     o_hash_word3,
    output logic [sflnh_pkg::BUCKET_W-1:0]  o_bucket
);
    import sflnh_pkg::*;

    localparam int unsigned REM_W   = $clog2(BUCKET_COUNT);
    localparam logic [63:0] RECIP64 = 64'h1_0000_0000 / 64'(BUCKET_COUNT);
    localparam logic [31:0] RECIP   = RECIP64[31:0];
    localparam logic [31:0] BCNT    = 32'(BUCKET_COUNT);
    localparam logic [31:0] BCNT2   = 32'(2 * BUCKET_COUNT);

    logic [63:0] r_gseed;

    t_fold       w_fold;

    logic        r_v1;
    logic        r_start1;
    logic        r_last1;
    logic        r_run1;
    logic [31:0] r_n1;
    logic [63:0] r_seed1;
    logic [15:0] r_len1;

    logic [31:0] r_lane_a, r_lane_b, r_lane_c, r_lane_d;
    logic [31:0] n_lane_a, n_lane_b, n_lane_c, n_lane_d;
    logic [31:0] w_base_b, w_base_c, w_x_bc;
    logic [31:0] w_mul_a, w_mul_b, w_mul_c, w_mul_d;

    logic        r_v2, r_v3, r_v4, r_v5, r_v6;
    t_hash       r_h2, r_h3, r_h4, r_h5, r_h6;
    t_hash       n_h3;
    logic [31:0] r_sum3, r_sum4, r_sum5;
    logic [31:0] r_q4;
    logic [31:0] r_qb5;
    logic [REM_W-1:0] r_rem6;

    logic [63:0] w_prod;
    logic [31:0] w_r, w_r1, w_r2, w_rem;

    logic        w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5, w_rdy6;
    logic        w_adv1;

    sflnh_word_fold u_fold (
        .i_data_word  (i_data_word),
        .i_byte_count (i_byte_count),
        .o_fold       (w_fold)
    );

    assign w_rdy6 = !r_v6 || !i_out_stall;
    assign w_rdy5 = !r_v5 || w_rdy6;
    assign w_rdy4 = !r_v4 || w_rdy5;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_adv1 = r_v1 && w_rdy2;

    assign o_in_stall = !w_rdy1;

    // lane round / start initialization
    always_comb begin
        w_base_b = r_start1 ? r_seed1[63:32] : r_lane_b;
        w_base_c = r_start1 ? r_gseed[31:0]  : r_lane_c;
        w_x_bc   = r_start1 ? {16'h0, r_len1} : r_n1;
        w_mul_a  = (r_lane_a + r_n1) * MUL_A;
        w_mul_b  = (w_base_b ^ w_x_bc) * MUL_B;
        w_mul_c  = (w_base_c + w_x_bc) * MUL_C;
        w_mul_d  = (r_lane_d ^ r_n1) * MUL_D;

        n_lane_a = r_lane_a;
        n_lane_b = r_lane_b;
        n_lane_c = r_lane_c;
        n_lane_d = r_lane_d;
        if (w_adv1) begin
            if (r_start1) begin
                n_lane_a = r_seed1[31:0];
                n_lane_b = w_mul_b;
                n_lane_c = w_mul_c;
                n_lane_d = r_gseed[63:32];
            end else if (r_run1) begin
                n_lane_a = w_mul_a;
                n_lane_b = w_mul_b;
                n_lane_c = w_mul_c;
                n_lane_d = w_mul_d;
            end
        end
    end

    always_comb begin
        n_h3.w0 = r_h2.w0 ^ (r_h2.w0 >> 17);
        n_h3.w1 = r_h2.w1;
        n_h3.w2 = r_h2.w2 ^ (r_h2.w2 >> 15);
        n_h3.w3 = r_h2.w3;
    end

    // bucket: reciprocal estimate, then up to two subtract corrections
    assign w_prod = {32'h0, r_sum3} * {32'h0, RECIP};
    assign w_r    = r_sum5 - r_qb5;
    assign w_r1   = w_r - BCNT;
    assign w_r2   = w_r - BCNT2;
    assign w_rem  = (w_r >= BCNT2) ? w_r2 : ((w_r >= BCNT) ? w_r1 : w_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gseed  <= '0;
            r_lane_a <= '0;
            r_lane_b <= '0;
            r_lane_c <= '0;
            r_lane_d <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_v4     <= 1'b0;
            r_v5     <= 1'b0;
            r_v6     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_gseed <= i_cfg_wr_data;
            end
            r_lane_a <= n_lane_a;
            r_lane_b <= n_lane_b;
            r_lane_c <= n_lane_c;
            r_lane_d <= n_lane_d;
            if (w_rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1 && r_last1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
            if (w_rdy6) begin
                r_v6 <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_rdy1) begin
            r_start1 <= i_start_req;
            r_last1  <= i_last;
            r_run1   <= w_fold.run;
            r_n1     <= w_fold.n;
            r_seed1  <= i_name_seed;
            r_len1   <= i_total_length;
        end
        if (w_rdy2 && r_v1 && r_last1) begin
            r_h2 <= '{w0: n_lane_a, w1: n_lane_b, w2: n_lane_c, w3: n_lane_d};
        end
        if (w_rdy3 && r_v2) begin
            r_h3   <= n_h3;
            r_sum3 <= n_h3.w0 + n_h3.w2;
        end
        if (w_rdy4 && r_v3) begin
            r_h4   <= r_h3;
            r_sum4 <= r_sum3;
            r_q4   <= w_prod[63:32];
        end
        if (w_rdy5 && r_v4) begin
            r_h5   <= r_h4;
            r_sum5 <= r_sum4;
            r_qb5  <= r_q4 * BCNT;
        end
        if (w_rdy6 && r_v5) begin
            r_h6   <= r_h5;
            r_rem6 <= w_rem[REM_W-1:0];
        end
    end

    assign o_out_valid  = r_v6;
    assign o_hash_word0 = r_h6.w0;
    assign o_hash_word1 = r_h6.w1;
    assign o_hash_word2 = r_h6.w2;
    assign o_hash_word3 = r_h6.w3;
    assign o_bucket     = BUCKET_W'(r_rem6);

    `SFLNH_ASSERT_SAME(a_rem_range, r_v6, 32'(r_rem6) < BCNT)
    `SFLNH_ASSERT_NEXT(a_lanes_hold, !w_adv1, $stable({r_lane_a, r_lane_b, r_lane_c, r_lane_d}))
    `SFLNH_ASSERT_SAME(a_result_from_last, $rose(r_v2), $past(r_v1 && r_last1))

endmodule

`default_nettype wire
